// File: hw/rtl/ade_pkg.sv
// Shared types and constants for the alternating direction diffusion step block.
`timescale 1ns / 1ps
`default_nettype none
package ade_pkg;
	localparam int unsigned ValueW = 32;
	localparam int unsigned AccW = 56;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_STEP  = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_CENTER     = 3'd0,
		REG_VERTICAL   = 3'd1,
		REG_HORIZONTAL = 3'd2,
		REG_CUTOFF     = 3'd3,
		REG_ROWS       = 3'd4,
		REG_COLS       = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [17:0] center;
		logic [15:0] vertical;
		logic [15:0] horizontal;
		logic [31:0] cutoff;
	} coef_t;
endpackage
`default_nettype wire

// File: hw/rtl/ade_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ade_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/ade_combine.sv
// Pipelined weighted sum, shift, saturation and cutoff for one cell update.
`timescale 1ns / 1ps
`default_nettype none
module ade_combine (
	input  wire logic                 clk,
	input  wire ade_pkg::coef_t       coef,
	input  wire logic [31:0]          ct,
	input  wire logic [31:0]          up,
	input  wire logic [31:0]          dn,
	input  wire logic [31:0]          lt,
	input  wire logic [31:0]          rt,
	output logic      [31:0]          res_s2,
	output logic                      sat_s2
);
	import ade_pkg::*;

	logic signed [AccW-1:0] pa_s1, pb_s1, pc_s1;
	logic signed [AccW-1:0] acc;
	logic [32:0] sum_v, sum_h;
	logic [AccW-17:0] q;
	logic [31:0] r;

	assign sum_v = {1'b0, up} + {1'b0, dn};
	assign sum_h = {1'b0, lt} + {1'b0, rt};

	always_ff @(posedge clk) begin
		pa_s1 <= AccW'(coef.center * $signed({1'b0, ct}));
		pb_s1 <= AccW'($signed({1'b0, coef.vertical}) * $signed({1'b0, sum_v}));
		pc_s1 <= AccW'($signed({1'b0, coef.horizontal}) * $signed({1'b0, sum_h}));
	end

	always_comb begin
		acc = pa_s1 + pb_s1 + pc_s1;
		q = acc[AccW-1:16];
		r = q[31:0];
		if (q[AccW-17:32] != '0) begin
			r = '1;
		end
		if (acc[AccW-1] || r <= coef.cutoff) begin
			r = '0;
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= r;
		sat_s2 <= !acc[AccW-1] && (q[AccW-17:32] != '0);
	end
endmodule
`default_nettype wire

// File: hw/rtl/ade_diffusion_grid_step.sv
// Top level: two grid memories and a sweep sequencer for the diffusion step.
// A write or unknown item goes straight to the result; a read passes through ST_RD and ST_RD2.
// A step visits every cell in both sweeps: it fetches and waits for each operand read, then
// combines and writes back; a padding neighbour skips the wait. An empty grid goes to the result.
// One item is in work at a time; the result register frees tready again once taken.
// Reset clears control state and restores register defaults; grid contents stay unknown.
`timescale 1ns / 1ps
`default_nettype none
module ade_diffusion_grid_step #(
	parameter int unsigned MAX_ROWS = 128,
	parameter int unsigned MAX_COLS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// mode[1:0], row[8:2], col[15:9], value[47:16]
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// concentration[31:0], saturated[32], zero fill above
	output logic      [39:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import ade_pkg::*;

	localparam int unsigned RW = $clog2(MAX_ROWS);
	localparam int unsigned CW = $clog2(MAX_COLS);
	localparam int unsigned AW = RW + CW;
	localparam int unsigned DEPTH = 1 << AW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_RD2, ST_FETCH, ST_WAIT, ST_CALC, ST_CALC2, ST_WB, ST_OUT
	} state_t;

	state_t state_q;
	coef_t coef_q;
	logic [7:0] rows_q, cols_q;
	logic [1:0] mode_q;
	logic [6:0] row_q, col_q;
	logic sweep_q;
	logic [10:0] r_q, c_q, nr_q, nc_q;
	logic [2:0] op_q;
	logic [31:0] opv_q [5];
	logic sat_q;
	logic [31:0] conc_q;
	logic out_sat_q;

	logic u_we, v_we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, u_rdata, v_rdata, res;
	logic res_sat;
	logic signed [11:0] nrow, ncol;
	logic in_bounds;

	ade_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mem (
		.clk, .we(u_we), .waddr, .wdata, .raddr, .rdata(u_rdata)
	);
	ade_ram #(.WIDTH(32), .DEPTH(DEPTH)) v_mem (
		.clk, .we(v_we), .waddr, .wdata, .raddr, .rdata(v_rdata)
	);

	ade_combine u_comb (
		.clk, .coef(coef_q), .ct(opv_q[0]), .up(opv_q[1]), .dn(opv_q[2]),
		.lt(opv_q[3]), .rt(opv_q[4]), .res_s2(res), .sat_s2(res_sat)
	);

	// Operand order: center, up, down, left, right.
	always_comb begin
		nrow = $signed({1'b0, r_q});
		ncol = $signed({1'b0, c_q});
		case (op_q)
			3'd1: nrow = nrow - 12'sd1;
			3'd2: nrow = nrow + 12'sd1;
			3'd3: ncol = ncol - 12'sd1;
			3'd4: ncol = ncol + 12'sd1;
			default: ;
		endcase
		in_bounds = !nrow[11] && !ncol[11] && (nrow < $signed({1'b0, nr_q}))
			&& (ncol < $signed({1'b0, nc_q}));
	end

	logic addr_ok;
	assign addr_ok = (32'(row_q) < MAX_ROWS) && (32'(col_q) < MAX_COLS);

	always_comb begin
		raddr = {nrow[RW-1:0], ncol[CW-1:0]};
		waddr = {r_q[RW-1:0], c_q[CW-1:0]};
		wdata = res;
		u_we = 1'b0;
		v_we = 1'b0;
		if (state_q == ST_RD) begin
			raddr = {RW'(row_q), CW'(col_q)};
		end
		if (state_q == ST_IDLE && s_tvalid && s_tdata[1:0] == MODE_WRITE
				&& (32'(s_tdata[8:2]) < MAX_ROWS) && (32'(s_tdata[15:9]) < MAX_COLS)) begin
			waddr = {RW'(s_tdata[8:2]), CW'(s_tdata[15:9])};
			wdata = s_tdata[47:16];
			u_we = 1'b1;
			v_we = 1'b1;
		end
		if (state_q == ST_WB) begin
			u_we = !sweep_q;
			v_we = sweep_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {7'd0, out_sat_q, conc_q};

	logic [10:0] rows_eff, cols_eff;
	assign rows_eff = (32'(rows_q) > MAX_ROWS) ? 11'(MAX_ROWS) : 11'(rows_q);
	assign cols_eff = (32'(cols_q) > MAX_COLS) ? 11'(MAX_COLS) : 11'(cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coef_q <= '{center: 18'sd65536, vertical: '0, horizontal: '0, cutoff: '0};
			rows_q <= 8'd128;
			cols_q <= 8'd128;
			sweep_q <= 1'b0;
			sat_q <= 1'b0;
			op_q <= '0;
			r_q <= '0;
			c_q <= '0;
			nr_q <= '0;
			nc_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CENTER:     coef_q.center <= $signed(cfg_data[17:0]);
					REG_VERTICAL:   coef_q.vertical <= cfg_data[15:0];
					REG_HORIZONTAL: coef_q.horizontal <= cfg_data[15:0];
					REG_CUTOFF:     coef_q.cutoff <= cfg_data;
					REG_ROWS:       rows_q <= cfg_data[7:0];
					REG_COLS:       cols_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					mode_q <= s_tdata[1:0];
					row_q <= s_tdata[8:2];
					col_q <= s_tdata[15:9];
					conc_q <= '0;
					out_sat_q <= 1'b0;
					sat_q <= 1'b0;
					sweep_q <= 1'b0;
					op_q <= '0;
					nr_q <= rows_eff;
					nc_q <= cols_eff;
					r_q <= '0;
					c_q <= '0;
					if (s_tdata[1:0] == MODE_STEP) begin
						state_q <= (rows_eff == 0 || cols_eff == 0) ? ST_OUT : ST_FETCH;
					end else if (s_tdata[1:0] == MODE_READ) begin
						state_q <= ST_RD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_RD: state_q <= ST_RD2;
				ST_RD2: begin
					conc_q <= addr_ok ? 32'((33'(u_rdata) + 33'(v_rdata)) >> 1) : '0;
					state_q <= ST_OUT;
				end
				ST_FETCH: begin
					opv_q[op_q] <= '0;
					state_q <= in_bounds ? ST_WAIT : ST_FETCH;
					if (!in_bounds) begin
						op_q <= op_q + 3'd1;
						if (op_q == 3'd4) begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_WAIT: begin
					opv_q[op_q] <= sweep_q ? v_rdata : u_rdata;
					op_q <= op_q + 3'd1;
					state_q <= (op_q == 3'd4) ? ST_CALC : ST_FETCH;
				end
				ST_CALC: state_q <= ST_CALC2;
				ST_CALC2: state_q <= ST_WB;
				ST_WB: begin
					sat_q <= sat_q | res_sat;
					op_q <= '0;
					state_q <= ST_FETCH;
					if (!sweep_q) begin
						if (c_q + 11'd1 < nc_q) begin
							c_q <= c_q + 11'd1;
						end else if (r_q + 11'd1 < nr_q) begin
							c_q <= '0;
							r_q <= r_q + 11'd1;
						end else begin
							sweep_q <= 1'b1;
							r_q <= nr_q - 11'd1;
							c_q <= nc_q - 11'd1;
						end
					end else begin
						if (c_q != 0) begin
							c_q <= c_q - 11'd1;
						end else if (r_q != 0) begin
							c_q <= nc_q - 11'd1;
							r_q <= r_q - 11'd1;
						end else begin
							out_sat_q <= sat_q | res_sat;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(u_we && state_q == ST_WB) |-> !v_we) else $error("both grids written in a sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> (r_q < nr_q && c_q < nc_q)) else $error("sweep out of area");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && mode_q != MODE_STEP) |-> !out_sat_q) else $error("flag on non-step");
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the alternating direction diffusion step block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import ade_pkg::*;

	localparam int GridRows = 128;
	localparam int GridCols = 128;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_CENTER;
	logic [31:0] cfg_data = '0;

	typedef struct packed {
		logic saturated;
		logic [31:0] concentration;
	} cell_result_t;

	ade_diffusion_grid_step dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [47:0] pending_items[$];
	cell_result_t expected_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	bit hold_req = 1'b0;

	// Predicted grid contents and register copies.
	logic [31:0] u_cells[GridRows * GridCols];
	logic [31:0] v_cells[GridRows * GridCols];
	bit planned[GridRows * GridCols];
	logic signed [17:0] w_center = 18'sd65536;
	logic [15:0] w_vert = '0;
	logic [15:0] w_horz = '0;
	logic [31:0] cutoff = '0;
	logic [7:0] rows_used = 8'd128;
	logic [7:0] cols_used = 8'd128;
	bit step_sat;

	always #10 clk = ~clk;

	function automatic logic [31:0] cell_at(bit use_u, int r, int c, int nr, int nc);
		if (r < 0 || c < 0 || r >= nr || c >= nc)
			return '0;
		return use_u ? u_cells[r * GridCols + c] : v_cells[r * GridCols + c];
	endfunction

	function automatic logic [31:0] diffuse_cell(bit use_u, int r, int c, int nr, int nc);
		longint acc;
		longint q;
		logic [31:0] res;
		acc = longint'(w_center) * longint'(cell_at(use_u, r, c, nr, nc))
			+ longint'(w_vert) * (longint'(cell_at(use_u, r - 1, c, nr, nc))
				+ longint'(cell_at(use_u, r + 1, c, nr, nc)))
			+ longint'(w_horz) * (longint'(cell_at(use_u, r, c - 1, nr, nc))
				+ longint'(cell_at(use_u, r, c + 1, nr, nc)));
		if (acc < 0)
			return '0;
		q = acc >>> 16;
		if (q > 64'hFFFF_FFFF) begin
			step_sat = 1'b1;
			res = 32'hFFFF_FFFF;
		end else begin
			res = q[31:0];
		end
		if (res <= cutoff)
			res = '0;
		return res;
	endfunction

	function automatic void predict_item(logic [47:0] item);
		mode_t mode;
		int idx;
		int nr;
		int nc;
		cell_result_t res;
		mode = mode_t'(item[1:0]);
		idx = int'(item[8:2]) * GridCols + int'(item[15:9]);
		res = '0;
		case (mode)
			MODE_WRITE: begin
				u_cells[idx] = item[47:16];
				v_cells[idx] = item[47:16];
			end
			MODE_STEP: begin
				nr = rows_used > GridRows ? GridRows : rows_used;
				nc = cols_used > GridCols ? GridCols : cols_used;
				step_sat = 1'b0;
				for (int r = 0; r < nr; r++)
					for (int c = 0; c < nc; c++)
						u_cells[r * GridCols + c] = diffuse_cell(1'b1, r, c, nr, nc);
				for (int r = nr - 1; r >= 0; r--)
					for (int c = nc - 1; c >= 0; c--)
						v_cells[r * GridCols + c] = diffuse_cell(1'b0, r, c, nr, nc);
				res.saturated = step_sat;
			end
			MODE_READ: res.concentration = 32'((33'(u_cells[idx]) + 33'(v_cells[idx])) >> 1);
			default: ;
		endcase
		expected_results.push_back(res);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_item(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_items.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles != 0)
			hold_cycles <= hold_cycles - 1;
		else if (hold_req)
			hold_cycles <= 400;
	end

	always @(posedge clk) begin
		cell_result_t got;
		cell_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[32:0];
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.concentration !== want.concentration) begin
					$display("%0t: concentration expected %h actual %h", $time,
						want.concentration, got.concentration);
					errors++;
				end
				if (got.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, got.saturated);
					errors++;
				end
				if (m_tdata[39:33] !== '0) begin
					$display("%0t: fill bits expected 0 actual %h", $time, m_tdata[39:33]);
					errors++;
				end
			end
		end
		m_tready <= arst_n && hold_cycles == 0 && !hold_req
			&& $urandom_range(99) >= recv_idle_pct;
	end

	function automatic logic [47:0] make_item(mode_t mode, int r, int c, logic [31:0] val);
		return {val, 7'(c), 7'(r), mode};
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(2))
			0: return $urandom_range(32'h000F_FFFF);
			1: return 32'hFFFF_0000 | $urandom_range(16'hFFFF);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_write(int r, int c, logic [31:0] val);
		pending_items.push_back(make_item(MODE_WRITE, r, c, val));
		planned[r * GridCols + c] = 1'b1;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic signed [17:0] a, logic [15:0] b, logic [15:0] c,
			logic [31:0] cut, logic [7:0] nr, logic [7:0] nc);
		reg_index_t regs[6];
		logic [31:0] vals[6];
		regs = '{REG_CENTER, REG_VERTICAL, REG_HORIZONTAL, REG_CUTOFF, REG_ROWS, REG_COLS};
		vals = '{32'(unsigned'(a)), 32'(b), 32'(c), cut, 32'(nr), 32'(nc)};
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		w_center = a;
		w_vert = b;
		w_horz = c;
		cutoff = cut;
		rows_used = nr;
		cols_used = nc;
	endtask

	task automatic run_phase(logic signed [17:0] a, logic [15:0] b, logic [15:0] c,
			logic [31:0] cut, logic [7:0] nr, logic [7:0] nc, int count);
		int er;
		int ec;
		int r;
		int k;
		set_config(a, b, c, cut, nr, nc);
		er = nr > GridRows ? GridRows : nr;
		ec = nc > GridCols ? GridCols : nc;
		for (int i = 0; i < er; i++)
			for (int j = 0; j < ec; j++)
				queue_write(i, j, random_value());
		pending_items.push_back(make_item(MODE_STEP, $urandom_range(127), $urandom_range(127),
			$urandom));
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(9);
			if (k < 3) begin
				pending_items.push_back(make_item(MODE_STEP, $urandom_range(127),
					$urandom_range(127), $urandom));
			end else if (k < 7) begin
				do r = $urandom_range(GridRows * GridCols - 1); while (!planned[r]);
				pending_items.push_back(make_item(MODE_READ, r / GridCols, r % GridCols,
					$urandom));
			end else if (k < 9) begin
				if ($urandom_range(1))
					queue_write($urandom_range(er - 1), $urandom_range(ec - 1), random_value());
				else
					queue_write($urandom_range(127), $urandom_range(127), random_value());
			end else begin
				pending_items.push_back(make_item(MODE_NONE, $urandom_range(127),
					$urandom_range(127), $urandom));
			end
		end
		wait_idle();
	endtask

	initial begin
		send_idle_pct = 32;
		recv_idle_pct = 80;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		queue_write(0, 0, 32'h0000_0000);
		queue_write(127, 127, 32'hFFFF_FFFF);
		queue_write(0, 127, 32'hAAAA_AAAA);
		queue_write(127, 0, 32'h5555_5555);
		pending_items.push_back(make_item(MODE_READ, 0, 0, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(MODE_READ, 127, 127, 32'h0));
		pending_items.push_back(make_item(MODE_READ, 0, 127, 32'h0));
		pending_items.push_back(make_item(MODE_READ, 127, 0, 32'h0));
		pending_items.push_back(make_item(MODE_NONE, 127, 127, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(MODE_NONE, 0, 0, 32'h0));
		pending_items.push_back(make_item(MODE_READ, 127, 127, 32'h0));
		wait_idle();

		run_phase(-18'sd131072, 16'hFFFF, 16'hFFFF, 32'h0, 8'd3, 8'd4, 6);
		run_phase(18'sd131071, 16'h0, 16'h0, 32'hFFFF_FFFF, 8'd4, 8'd2, 6);
		run_phase(18'sd65536, 16'd8000, 16'd0, 32'd100, 8'd6, 8'd1, 6);
		send_idle_pct = 80;
		recv_idle_pct = 32;
		run_phase(18'sd40000, 16'd6000, 16'd6000, 32'd0, 8'd5, 8'd0, 6);
		run_phase(18'sd32768, 16'd0, 16'd16384, 32'd5000, 8'd1, 8'd6, 6);
		hold_req = 1'b1;
		fork
			run_phase(18'($urandom), 16'($urandom), 16'($urandom), $urandom_range(1000),
				8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 8);
			begin
				while (hold_cycles == 0)
					@(posedge clk);
				hold_req = 1'b0;
			end
		join
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(18'($urandom), 16'($urandom), 16'($urandom), $urandom_range(1000),
			8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)), 8);

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
